// ----- sv/keyframe_matrix_interpolator_top_macros.svh -----
// Assertion macros used by the keyframe matrix interpolator controller.
`ifndef KEYFRAME_MATRIX_INTERPOLATOR_TOP_MACROS_SVH
`define KEYFRAME_MATRIX_INTERPOLATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define KMI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define KMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/kmi_pkg.sv -----
// Package: types, codes and constants of the keyframe matrix interpolator.
`default_nettype none
package kmi_pkg;

  localparam int unsigned MaxKeyframes = 16;
  localparam int unsigned KeyW = 4;
  localparam int unsigned ElemW = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned DivSteps = 16;
  localparam logic [31:0] QOne = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_WR_ELEM = 2'd0,
    OP_WR_DUR  = 2'd1,
    OP_TICK    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_READ,
    ST_MUL,
    ST_EMIT
  } state_e;

  localparam logic REG_KF_COUNT = 1'b0;

  typedef struct packed {
    logic             wr_elem;
    logic             wr_dur;
    logic             tick;
    logic             scan;
    logic             div_init;
    logic             div_step;
    logic             rd;
    logic             mul;
    logic             emit;
    logic             found;
    logic             ident;
    logic [KeyW-1:0]  cur_key;
    logic [KeyW-1:0]  prev_key;
    logic [ElemW-1:0] elem;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } status_t;

  function automatic logic [31:0] identity_elem(input logic [ElemW-1:0] k);
    logic diag;
    diag = (k == 4'd0) || (k == 4'd5) || (k == 4'd10) || (k == 4'd15);
    return diag ? QOne : 32'h0;
  endfunction

endpackage
`default_nettype wire

// ----- sv/kmi_if.sv -----
// Request channel interfaces: input items and result elements.
`default_nettype none
interface kmi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         key_index;
  logic [3:0]         element_index;
  logic signed [31:0] element_value;
  logic [31:0]        duration_value;
  logic [31:0]        delta_time;
  modport source (output valid, op, key_index, element_index, element_value,
                  duration_value, delta_time, input ready);
  modport sink (input valid, op, key_index, element_index, element_value,
                duration_value, delta_time, output ready);
endinterface

interface kmi_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_index;
  logic signed [31:0] out_value;
  logic               finished;
  logic               last;
  modport source (output valid, out_index, out_value, finished, last, input ready);
  modport sink (input valid, out_index, out_value, finished, last, output ready);
endinterface
`default_nettype wire

// ----- sv/keyframe_matrix_interpolator_top.sv -----
// Top level: keyframe matrix interpolator with APB count register.
//
//  channel  dir  handshake          carries
//  in_if    in   valid/ready        op, key/element index, element, duration, delta
//  out_if   out  valid/ready        out_index, out_value, finished, last
//  apb      in   psel/penable/pwrite keyframe_count at byte 0
//
// Writes (op 0/1) and the unused op complete in the state that accepts them.
// A tick scans the keyframes passed, runs the divider when an interval holds
// the time, then reads, multiplies and emits each element in turn.
// The divider is restoring, one quotient bit a cycle; the emit step of each
// element waits while the output register is still full.
// Reset clears the elapsed time, the count and all control; the tables are not cleared.
// A stalled out_if holds the element sequence; a new request waits until the run ends.
`default_nettype none
module keyframe_matrix_interpolator_top
  import kmi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  kmi_in_if.sink           in_if,
  kmi_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [CountW-1:0] kf_count_q, kf_count_d;
  logic [CountW-1:0] count_clamped;
  cmd_t cmd;
  status_t status;

  // Register word select is paddr[2]; only word 0 exists.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KF_COUNT) ? {27'h0, kf_count_q} : 32'h0;

  always_comb begin
    kf_count_d = kf_count_q;
    if (psel && penable && pwrite && paddr[2] == REG_KF_COUNT) begin
      kf_count_d = pwdata[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kf_count_q <= '0;
    end else begin
      kf_count_q <= kf_count_d;
    end
  end

  // Counts above the table depth act as a full table.
  assign count_clamped = (kf_count_q > CountW'(MaxKeyframes)) ? CountW'(MaxKeyframes)
                                                             : kf_count_q;

  kmi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_op_i    (in_if.op),
    .in_ready_o (in_if.ready),
    .count_i    (count_clamped),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kmi_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .key_index_i      (in_if.key_index),
    .element_index_i  (in_if.element_index),
    .element_value_i  (in_if.element_value),
    .duration_value_i (in_if.duration_value),
    .delta_time_i     (in_if.delta_time),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_if           (out_if)
  );

endmodule
`default_nettype wire

// ----- sv/kmi_ctrl.sv -----
// Controller: sequences writes, keyframe scan, divide and per-element blend.
`default_nettype none
module kmi_ctrl
  import kmi_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_op_i,
  output logic                   in_ready_o,
  input  wire logic [CountW-1:0] count_i,
  input  wire status_t           status_i,
  output cmd_t                   cmd_o
);
`include "keyframe_matrix_interpolator_top_macros.svh"

  state_e state_q, state_d;
  logic [CountW-1:0] scan_idx_q, scan_idx_d;
  logic [3:0] div_cnt_q, div_cnt_d;
  logic [ElemW-1:0] elem_q, elem_d;
  logic found_q, found_d;
  logic [CountW-1:0] count_m1;
  logic [KeyW-1:0] cur_key;
  logic accept;

  assign count_m1 = count_i - CountW'(1);
  assign cur_key = (state_q == ST_SCAN || found_q) ? scan_idx_q[KeyW-1:0]
                                                   : count_m1[KeyW-1:0];
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_idx_q <= '0;
      div_cnt_q  <= '0;
      elem_q     <= '0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      div_cnt_q  <= div_cnt_d;
      elem_q     <= elem_d;
      found_q    <= found_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    div_cnt_d  = div_cnt_q;
    elem_d     = elem_q;
    found_d    = found_q;
    in_ready_o = 1'b0;
    cmd_o          = '0;
    cmd_o.found    = found_q;
    cmd_o.ident    = (count_i == '0);
    cmd_o.cur_key  = cur_key;
    cmd_o.prev_key = (found_q && cur_key != '0) ? cur_key - KeyW'(1) : cur_key;
    cmd_o.elem     = elem_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (op_e'(in_op_i))
            OP_WR_ELEM: cmd_o.wr_elem = 1'b1;
            OP_WR_DUR:  cmd_o.wr_dur = 1'b1;
            OP_TICK: begin
              cmd_o.tick = 1'b1;
              scan_idx_d = '0;
              found_d    = 1'b0;
              state_d    = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_idx_q >= count_i) begin
          found_d = 1'b0;
          elem_d  = '0;
          state_d = ST_READ;
        end else if (status_i.hit) begin
          cmd_o.div_init = 1'b1;
          found_d   = 1'b1;
          div_cnt_d = '0;
          state_d   = ST_DIV;
        end else begin
          cmd_o.scan = 1'b1;
          scan_idx_d = scan_idx_q + CountW'(1);
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d = div_cnt_q + 4'd1;
        if (div_cnt_q == 4'(DivSteps - 1)) begin
          elem_d  = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          elem_d = elem_q + ElemW'(1);
          state_d = (elem_q == '1) ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `KMI_ASSERT_NOW(a_emit_free, cmd_o.emit, status_i.out_free, "emit into a full output register")
  `KMI_ASSERT_NEXT(a_tick_scan, accept && in_op_i == OP_TICK, state_q == ST_SCAN,
    "tick did not start the scan")
  `KMI_ASSERT_NOW(a_found_range, state_q == ST_READ && found_q, scan_idx_q < count_i,
    "blend interval beyond keyframe count")
  `KMI_ASSERT_NOW(a_busy_stall, state_q != ST_IDLE, !in_ready_o, "request taken while busy")

endmodule
`default_nettype wire

// ----- sv/kmi_datapath.sv -----
// Datapath: keyframe store, elapsed time, divider, blend and result register.
`default_nettype none
module kmi_datapath
  import kmi_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [KeyW-1:0]    key_index_i,
  input  wire logic [ElemW-1:0]   element_index_i,
  input  wire logic signed [31:0] element_value_i,
  input  wire logic [31:0]        duration_value_i,
  input  wire logic [31:0]        delta_time_i,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  kmi_out_if.source               out_if
);

  logic [31:0] mat_mem [MaxKeyframes*16];
  logic [31:0] dur_q [MaxKeyframes];

  logic [31:0] time_q, start_q, rem_q, dvs_q;
  logic [15:0] quo_q;
  logic [32:0] tsum, end_sum, rem_sh;
  logic [31:0] cur_dur;
  logic [31:0] a_q, b_q, a2_q;
  logic signed [49:0] prod_q;
  logic signed [32:0] diff;
  logic [15:0] f;
  logic [50:0] bsum;

  logic out_valid_q;
  logic [3:0] out_index_q;
  logic [31:0] out_value_q;
  logic out_fin_q, out_last_q;

  assign cur_dur = dur_q[cmd_i.cur_key];
  assign end_sum = {1'b0, start_q} + {1'b0, cur_dur};
  assign tsum = {1'b0, time_q} + {1'b0, delta_time_i};
  assign rem_sh = {rem_q, 1'b0};
  assign f = cmd_i.found ? quo_q : 16'h0;
  assign diff = $signed({b_q[31], b_q}) - $signed({a_q[31], a_q});
  assign bsum = {{3{a2_q[31]}}, a2_q, 16'h0} + {prod_q[49], prod_q} + 51'd32768;

  assign status_o.hit = {1'b0, time_q} < end_sum;
  assign status_o.out_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_elem) begin
      mat_mem[{key_index_i, element_index_i}] <= element_value_i;
    end
    if (cmd_i.rd) begin
      a_q <= mat_mem[{cmd_i.prev_key, cmd_i.elem}];
      b_q <= mat_mem[{cmd_i.cur_key, cmd_i.elem}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_dur) begin
      dur_q[key_index_i] <= duration_value_i;
    end
    if (cmd_i.tick) begin
      start_q <= '0;
    end else if (cmd_i.scan) begin
      start_q <= end_sum[31:0];
    end
    if (cmd_i.div_init) begin
      rem_q <= time_q - start_q;
      dvs_q <= cur_dur;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q <= 32'(rem_sh - {1'b0, dvs_q});
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    if (cmd_i.mul) begin
      prod_q <= diff * $signed({1'b0, f});
      a2_q   <= a_q;
    end
    if (cmd_i.emit) begin
      out_index_q <= cmd_i.elem;
      out_value_q <= cmd_i.ident ? identity_elem(cmd_i.elem) : bsum[47:16];
      out_fin_q   <= !cmd_i.found;
      out_last_q  <= (cmd_i.elem == '1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.tick) begin
        time_q <= tsum[32] ? '1 : tsum[31:0];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.out_index = out_index_q;
  assign out_if.out_value = out_value_q;
  assign out_if.finished  = out_fin_q;
  assign out_if.last      = out_last_q;

endmodule
`default_nettype wire

// ----- dv/tb_keyframe_matrix_interpolator_top.sv -----
// Testbench: keyframe matrix interpolator top, self-checking against its own predictor.
`default_nettype none
module tb_keyframe_matrix_interpolator_top;
  import kmi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One request on the input channel. A set ident flag means the expected
  // output is the identity with finished high, typed in instead of predicted.
  typedef struct {
    op_e         op;
    logic [3:0]  key;
    logic [3:0]  elem;
    logic [31:0] ev;
    logic [31:0] dv;
    logic [31:0] dt;
    bit          ident;
  } kf_req_t;

  // One emitted element as the output channel should show it.
  typedef struct {
    logic [3:0]  idx;
    logic [31:0] val;
    logic        fin;
    logic        last;
  } elem_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kmi_in_if  in_if();
  kmi_out_if out_if();

  keyframe_matrix_interpolator_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if.sink),
    .out_if  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow state of the block, kept in step with every accepted request.
  logic [31:0] kf_mat [256];
  logic [31:0] kf_dur [16];
  logic [31:0] elapsed;
  logic [4:0]  kf_count;

  elem_exp_t matrix_q[$];   // elements still owed by the block

  int  errors;
  int  ticks_sent;
  int  elems_seen;
  int  finished_seen;
  int  hold_left;           // long receiver hold-off, counted by the receiver
  bit  calm;                // no idling on either side

  // Round-half-up blend of two Q16.16 elements with a Q0.16 factor.
  function automatic logic [31:0] mix_elem(logic [31:0] a, logic [31:0] b,
                                           longint unsigned f);
    longint s;
    s = longint'($signed(a)) * (65536 - longint'(f)) + longint'($signed(b)) * longint'(f)
        + 32768;
    return 32'(s >>> 16);
  endfunction

  // Applies one accepted request to the shadow state; ticks queue 16 elements.
  task automatic apply_req(input kf_req_t r);
    longint unsigned sum, t, start, d, f;
    int              n, i, p, k;
    bit              hit;
    logic [31:0]     m [16];
    logic            fin;
    elem_exp_t       e;
    begin
      case (r.op)
        OP_WR_ELEM: kf_mat[r.key * 16 + r.elem] = r.ev;
        OP_WR_DUR:  kf_dur[r.key] = r.dv;
        OP_TICK: begin
          sum = longint'(elapsed) + longint'(r.dt);
          elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
          t = elapsed;
          n = (kf_count > MaxKeyframes) ? MaxKeyframes : kf_count;
          start = 0;
          hit = 1'b0;
          i = 0;
          while (i < n && !hit) begin
            d = kf_dur[i];
            if (t >= start && t < start + d) hit = 1'b1;
            else begin
              start += d;
              i++;
            end
          end
          fin = !hit;
          if (hit) begin
            f = ((t - start) << 16) / longint'(kf_dur[i]);
            p = (i > 0) ? i - 1 : 0;
            for (k = 0; k < 16; k++) m[k] = mix_elem(kf_mat[p*16+k], kf_mat[i*16+k], f);
          end else if (n == 0) begin
            for (k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? QOne : 32'h0;
          end else begin
            for (k = 0; k < 16; k++) m[k] = kf_mat[(n-1)*16+k];
          end
          // Rows with a typed expectation: empty table, identity, finished.
          if (r.ident) begin
            for (k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;
            fin = 1'b1;
          end
          for (k = 0; k < 16; k++) begin
            e.idx = 4'(k);
            e.val = m[k];
            e.fin = fin;
            e.last = (k == 15);
            matrix_q.push_back(e);
          end
          ticks_sent++;
        end
        default: ;
      endcase
    end
  endtask

  // Offers one request and holds it until accepted, then maybe idles.
  task automatic send_req(input kf_req_t r);
    int gap;
    begin
      in_if.op             <= r.op;
      in_if.key_index      <= r.key;
      in_if.element_index  <= r.elem;
      in_if.element_value  <= r.ev;
      in_if.duration_value <= r.dv;
      in_if.delta_time     <= r.dt;
      in_if.valid          <= 1'b1;
      do @(posedge clk_i); while (!in_if.ready);
      apply_req(r);
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Register write: setup phase, then access phase.
  task automatic write_count(input logic [31:0] v);
    begin
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= 3'(4 * REG_KF_COUNT);
      pwdata  <= v;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      kf_count = v[4:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  // Drains all owed elements, then lets a write that made no output settle.
  task automatic drain;
    begin
      in_if.valid <= 1'b0;
      while (matrix_q.size() != 0) @(posedge clk_i);
      repeat (8) @(posedge clk_i);
    end
  endtask

  task automatic rand_req(output kf_req_t r);
    int sel;
    begin
      sel = $urandom_range(0, 99);
      r.key = 4'($urandom_range(0, 15));
      r.elem = 4'($urandom_range(0, 15));
      r.ev = $urandom();
      r.dv = ($urandom_range(0, 9) == 0) ? 32'h0 : 32'($urandom_range(1 << 20, 1 << 24));
      if ($urandom_range(0, 19) == 0) r.dv = $urandom();
      r.dt = ($urandom_range(0, 7) == 0) ? 32'h0 : 32'($urandom_range(0, 1 << 19));
      r.ident = 1'b0;
      if (sel < 45)      r.op = OP_TICK;
      else if (sel < 80) r.op = OP_WR_ELEM;
      else if (sel < 95) r.op = OP_WR_DUR;
      else               r.op = OP_NOP;
    end
  endtask

  // Directed rows. The table is empty after reset, so those ticks give identity.
  kf_req_t directed [] = '{
    '{OP_TICK,    4'd0,  4'd0,  32'h0,         32'h0,         32'h0,      1'b1},
    '{OP_TICK,    4'd0,  4'd0,  32'h0,         32'h0,         32'h1,      1'b1},
    '{OP_NOP,     4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF,   1'b0},
    '{OP_WR_ELEM, 4'd0,  4'd0,  32'h8000_0000, 32'h0,         32'h0,      1'b0},
    '{OP_WR_ELEM, 4'd15, 4'd15, 32'h7FFF_FFFF, 32'h0,         32'h0,      1'b0},
    '{OP_WR_ELEM, 4'd5,  4'd10, 32'hFFFF_FFFF, 32'h0,         32'h0,      1'b0},
    '{OP_WR_DUR,  4'd0,  4'd0,  32'h0,         32'hFFFF_FFFF, 32'h0,      1'b0},
    '{OP_WR_DUR,  4'd15, 4'd0,  32'h0,         32'h0,         32'h0,      1'b0},
    '{OP_TICK,    4'd0,  4'd0,  32'h0,         32'h0,         32'h100,    1'b1},
    '{OP_NOP,     4'd0,  4'd0,  32'h0,         32'h0,         32'h0,      1'b0}
  };

  // Receiver: checks each accepted element and paces ready.
  initial begin
    int        burst;
    elem_exp_t e;
    burst = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        elems_seen++;
        if (matrix_q.size() == 0) begin
          $display("%0t: element %0d with nothing owed (value %h)", $time,
                   out_if.out_index, out_if.out_value);
          errors++;
        end else begin
          e = matrix_q.pop_front();
          if (out_if.out_index !== e.idx || out_if.out_value !== e.val ||
              out_if.finished !== e.fin || out_if.last !== e.last) begin
            $display("%0t: mismatch expected idx %0d val %h fin %b last %b", $time,
                     e.idx, e.val, e.fin, e.last);
            $display("%0t:          actual   idx %0d val %h fin %b last %b", $time,
                     out_if.out_index, out_if.out_value, out_if.finished, out_if.last);
            errors++;
          end
          if (e.fin && e.last) finished_seen++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("%0t: timeout, %0d elements still owed", $time, matrix_q.size());
    $display("[keyframe_matrix_interpolator_top] ERROR");
    $finish;
  end

  initial begin
    kf_req_t r;
    int      k, ph, n;
    logic [31:0] counts [6];
    errors = 0;
    ticks_sent = 0;
    elems_seen = 0;
    finished_seen = 0;
    hold_left = 0;
    calm = 1'b0;
    elapsed = 32'h0;
    kf_count = 5'd0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'h0;
    pwdata <= 32'h0;
    in_if.valid <= 1'b0;
    in_if.op <= OP_NOP;
    in_if.key_index <= 4'h0;
    in_if.element_index <= 4'h0;
    in_if.element_value <= 32'h0;
    in_if.duration_value <= 32'h0;
    in_if.delta_time <= 32'h0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_req(directed[i]);

    // Load every keyframe so no later scan can touch an unwritten entry.
    // Keyframe 3 keeps a zero duration: it must never hold the time.
    r.ident = 1'b0;
    r.dv = 32'h0;
    r.dt = 32'h0;
    for (k = 0; k < 256; k++) begin
      r.op = OP_WR_ELEM;
      r.key = 4'(k / 16);
      r.elem = 4'(k % 16);
      r.ev = $urandom();
      send_req(r);
    end
    for (k = 0; k < 16; k++) begin
      r.op = OP_WR_DUR;
      r.key = 4'(k);
      r.dv = (k == 3) ? 32'h0 : 32'($urandom_range(1 << 21, 1 << 24));
      send_req(r);
    end
    drain();

    // End exactly at the total: one keyframe whose length equals the new time.
    write_count(32'd1);
    r.op = OP_WR_DUR; r.key = 4'd0; r.dv = elapsed + 32'd5;
    send_req(r);
    r.op = OP_TICK; r.dt = 32'd5;
    send_req(r);
    r.op = OP_WR_DUR; r.dv = elapsed + 32'(1 << 22);
    send_req(r);
    drain();

    // Random phases over several table sizes, out-of-range count included.
    counts = '{32'd16, 32'd2, 32'd31, 32'd0, 32'($urandom_range(1, 15)), 32'd16};
    for (ph = 0; ph < 6; ph++) begin
      write_count(counts[ph]);
      calm = (ph == 5);
      for (n = 0; n < 27; n++) begin
        if (ph == 0 && n == 10) hold_left = 400;
        rand_req(r);
        send_req(r);
      end
      drain();
    end

    // Saturate the elapsed time; from here every tick reports the end.
    r.op = OP_TICK; r.dt = 32'hFFFF_FFFF; r.ident = 1'b0;
    send_req(r);
    r.dt = 32'd7;
    send_req(r);
    drain();
    repeat (200) @(posedge clk_i);

    $display("ran %0d ticks over table sizes 0..31 with idling and one long hold-off",
             ticks_sent);
    $display("checked %0d elements, %0d end-of-animation matrices", elems_seen,
             finished_seen);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("[keyframe_matrix_interpolator_top] OK");
    end else begin
      $display("[keyframe_matrix_interpolator_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
